FILE: src/ptta_pkg.sv
// shared types and constants for the pulse train timestamp averager
`timescale 1ns / 1ps

package ptta_pkg;

    localparam int SEC_W = 32;
    localparam int USEC_W = 20;
    localparam int CFG_W = 20;
    localparam int CFG_IDX_W = 2;

    localparam int USEC_PER_SEC = 1000000;

    localparam logic [CFG_W-1:0] SPACING_RESET = 20'd200000;
    localparam logic [CFG_W-1:0] SETTLE_RESET = 20'd300000;
    localparam logic [CFG_W-1:0] MARGIN_RESET = 20'd100000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_SPACING = 2'd0,
        REG_SETTLE_WAIT = 2'd1,
        REG_SPAN_MARGIN = 2'd2
    } cfg_reg_t;

    localparam logic EVENT_PULSE = 1'b0;
    localparam logic EVENT_TICK = 1'b1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_NOT_FILLED = 1'b1;

endpackage

FILE: src/pulse_train_timestamp_averager_unit.sv
// top level of the pulse train timestamp averager
`timescale 1ns / 1ps

// input channel: one word per event, event_kind selects pulse capture or tick
// with the current time; a word is taken when in_valid is high and in_stall low
// output channel: one word per finished average (status, seconds, microseconds),
// taken when out_valid is high and out_stall low
// configuration: cfg_wr_en writes cfg_data into the register picked by cfg_index
// throughput: one input word per cycle while in_stall is low; pulse words and ticks
// that give no result leave the pipeline at the input register
// a tick that closes a train reaches out_valid through the input, capture,
// division and scaling registers and the output register
// the only loop is the history and armed flag, updated as a word leaves the
// input register, so a new word may follow every cycle while in_stall is low
// reset: history cleared to zero, block disarmed, registers at their defaults
// when out_stall holds the output word, the stages behind it keep filling and
// in_stall rises only once every stage holds a word

module pulse_train_timestamp_averager_unit #(
    parameter int PULSE_COUNT = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                event_kind,
    input  logic [ptta_pkg::SEC_W-1:0]          time_seconds,
    input  logic [ptta_pkg::USEC_W-1:0]         time_microseconds,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                status,
    output logic [ptta_pkg::SEC_W-1:0]          avg_seconds,
    output logic [ptta_pkg::USEC_W-1:0]         avg_microseconds,
    input  logic                                cfg_wr_en,
    input  logic [ptta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptta_pkg::CFG_W-1:0]          cfg_data
);

    localparam int LAST = PULSE_COUNT - 1;
    localparam int LOGN = $clog2(PULSE_COUNT);
    localparam int K_SUM = PULSE_COUNT * (PULSE_COUNT - 1) / 2;
    localparam int SW = ptta_pkg::SEC_W;
    localparam int UW0 = ptta_pkg::USEC_W;

    // offset sum of seconds differences, long division by digit
    localparam int WD = SW + 1 + LOGN;
    localparam int NCH = (WD + 7) / 8;
    localparam int PW = NCH * 8;
    localparam int VW = LOGN + 8;
    localparam int S_D = VW + LOGN;
    localparam int RDW = S_D + 1;
    localparam int RECIP_D = ((1 << S_D) + PULSE_COUNT - 1) / PULSE_COUNT;
    localparam logic [WD-1:0] DS_OFFSET = WD'(PULSE_COUNT) << SW;

    // microsecond sum and division by the pulse count
    localparam int UW = UW0 + 1 + $clog2(PULSE_COUNT + K_SUM);
    localparam int S_M = UW + LOGN;
    localparam int RMW = S_M + 1;
    localparam longint unsigned RECIP_M =
        ((64'd1 << S_M) + PULSE_COUNT - 1) / PULSE_COUNT;

    localparam int LW = UW0 + 1 + LOGN;
    localparam int SPW = 54;
    localparam logic signed [SPW-1:0] USEC_S = SPW'(ptta_pkg::USEC_PER_SEC);

    localparam int CMAX = int'(((64'd1 << UW) / PULSE_COUNT) / 1000000) + 1;
    localparam int CW = $clog2(CMAX + 1);

    // configuration
    logic [ptta_pkg::CFG_W-1:0] spacing_reg;
    logic [ptta_pkg::CFG_W-1:0] settle_reg;
    logic [ptta_pkg::CFG_W-1:0] margin_reg;

    // state
    logic [SW-1:0]  sec_hist_reg [PULSE_COUNT];
    logic [UW0-1:0] us_hist_reg [PULSE_COUNT];
    logic           armed_reg;

    // input stage
    logic           a_valid_reg;
    logic           a_kind_reg;
    logic [SW-1:0]  a_sec_reg;
    logic [UW0-1:0] a_us_reg;

    // capture stage
    logic                    b_valid_reg;
    logic [WD-1:0]           b_dso_reg;
    logic [UW-1:0]           b_usum_reg;
    logic signed [SW:0]      b_span_s_reg;
    logic signed [UW0:0]     b_span_u_reg;
    logic [LW-1:0]           b_limit_reg;
    logic [SW-1:0]           b_base_reg;

    // division stage
    logic                    c_valid_reg;
    logic signed [SPW-1:0]   c_span_reg;
    logic [LW-1:0]           c_limit_reg;
    logic [LOGN-1:0]         c_rem_reg;
    logic [UW-1:0]           c_usum_reg;
    logic [SW-1:0]           c_base_reg;
    logic [SW-1:0]           c_q_reg;

    // scaling stage
    logic                    d_valid_reg;
    logic                    d_fail_reg;
    logic [UW-1:0]           d_m_reg;
    logic [SW-1:0]           d_sec_reg;

    // output register
    logic                    out_valid_reg;
    logic                    status_reg;
    logic [SW-1:0]           avg_sec_reg;
    logic [UW0-1:0]          avg_us_reg;

    logic en_out;
    logic en_d;
    logic en_c;
    logic en_b;
    logic en_a;
    logic fire;

    logic signed [SW:0]   ds;
    logic signed [21:0]   d_us;
    logic                 elapsed;
    logic                 emit;

    logic [WD-1:0]        dso;
    logic [UW-1:0]        usum;
    logic signed [SW:0]   span_s;
    logic signed [UW0:0]  span_u;
    logic [LW-1:0]        limit;

    logic [PW-1:0]        pad;
    logic [PW-1:0]        qpad;
    logic [LOGN-1:0]      rem;
    logic [VW-1:0]        dv;
    logic [VW+RDW-1:0]    dprod;
    logic [7:0]           qd;
    logic signed [SPW-1:0] span_c;

    logic                 fail;
    logic [UW-1:0]        num;
    logic [UW+RMW-1:0]    mprod;
    logic [UW-1:0]        m_val;

    logic [CW-1:0]        carry_s;
    logic [UW-1:0]        carry_sub;

    // handshake chain
    assign en_out = !out_valid_reg || !out_stall;
    assign en_d = !d_valid_reg || en_out;
    assign en_c = !c_valid_reg || en_d;
    assign en_b = !b_valid_reg || en_c;
    assign en_a = !a_valid_reg || en_b;
    assign fire = a_valid_reg && en_b;
    assign in_stall = !en_a;

    // settle check against newest pulse
    always_comb
    begin
        ds = $signed({1'b0, a_sec_reg}) - $signed({1'b0, sec_hist_reg[0]});
        d_us = (ds[0] ? 22'sd1000000 : 22'sd0) + $signed({2'b00, a_us_reg})
               - $signed({2'b00, us_hist_reg[0]});
        elapsed = ds[SW] || (ds > 33'sd1) || d_us[21]
                  || (d_us > $signed({2'b00, settle_reg}));
        emit = (a_kind_reg == ptta_pkg::EVENT_TICK) && armed_reg && elapsed;
    end

    // snapshot sums of the history
    always_comb
    begin
        dso = DS_OFFSET;
        for (int i = 0; i < LAST; i++)
        begin
            dso = dso + WD'(sec_hist_reg[i]) - WD'(sec_hist_reg[LAST]);
        end
        usum = UW'(K_SUM) * UW'(spacing_reg);
        for (int i = 0; i < PULSE_COUNT; i++)
        begin
            usum = usum + UW'(us_hist_reg[i]);
        end
        span_s = $signed({1'b0, sec_hist_reg[0]}) - $signed({1'b0, sec_hist_reg[LAST]});
        span_u = $signed({1'b0, us_hist_reg[0]}) - $signed({1'b0, us_hist_reg[LAST]});
        limit = LW'(LAST) * LW'(spacing_reg) + LW'(margin_reg);
    end

    // digit long division of the offset seconds sum
    always_comb
    begin
        pad = PW'(b_dso_reg);
        qpad = '0;
        rem = '0;
        dv = '0;
        dprod = '0;
        qd = '0;
        for (int k = NCH - 1; k >= 0; k--)
        begin
            dv = {rem, pad[k*8 +: 8]};
            dprod = (VW + RDW)'(dv) * (VW + RDW)'(RECIP_D);
            qd = dprod[S_D +: 8];
            rem = LOGN'(dv - VW'(qd) * VW'(PULSE_COUNT));
            qpad[k*8 +: 8] = qd;
        end
        span_c = SPW'(b_span_s_reg) * USEC_S + SPW'(b_span_u_reg);
    end

    // span check and microsecond mean
    always_comb
    begin
        fail = c_span_reg[SPW-1] || (c_span_reg > $signed(SPW'(c_limit_reg)));
        num = UW'(c_rem_reg) * UW'(ptta_pkg::USEC_PER_SEC) + c_usum_reg;
        mprod = (UW + RMW)'(num) * (UW + RMW)'(RECIP_M);
        m_val = mprod[S_M +: UW];
    end

    // whole seconds carried out of the mean
    always_comb
    begin
        carry_s = '0;
        carry_sub = '0;
        for (int k = 1; k <= CMAX; k++)
        begin
            if (64'(d_m_reg) >= 64'(k) * 64'(ptta_pkg::USEC_PER_SEC))
            begin
                carry_s = CW'(k);
                carry_sub = UW'(64'(k) * 64'(ptta_pkg::USEC_PER_SEC));
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= ptta_pkg::SPACING_RESET;
            settle_reg <= ptta_pkg::SETTLE_RESET;
            margin_reg <= ptta_pkg::MARGIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ptta_pkg::REG_PULSE_SPACING: spacing_reg <= cfg_data;
                ptta_pkg::REG_SETTLE_WAIT:   settle_reg <= cfg_data;
                ptta_pkg::REG_SPAN_MARGIN:   margin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // history and armed flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PULSE_COUNT; i++)
            begin
                sec_hist_reg[i] <= '0;
                us_hist_reg[i] <= '0;
            end
            armed_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (a_kind_reg == ptta_pkg::EVENT_PULSE)
            begin
                for (int i = LAST; i > 0; i--)
                begin
                    sec_hist_reg[i] <= sec_hist_reg[i-1];
                    us_hist_reg[i] <= us_hist_reg[i-1];
                end
                sec_hist_reg[0] <= a_sec_reg;
                us_hist_reg[0] <= a_us_reg;
                armed_reg <= 1'b1;
            end
            else if (emit)
            begin
                armed_reg <= 1'b0;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= fire && emit;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (en_d)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= d_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && en_a)
        begin
            a_kind_reg <= event_kind;
            a_sec_reg <= time_seconds;
            a_us_reg <= time_microseconds;
        end
        if (fire && emit)
        begin
            b_dso_reg <= dso;
            b_usum_reg <= usum;
            b_span_s_reg <= span_s;
            b_span_u_reg <= span_u;
            b_limit_reg <= limit;
            b_base_reg <= sec_hist_reg[LAST];
        end
        if (b_valid_reg && en_c)
        begin
            c_span_reg <= span_c;
            c_limit_reg <= b_limit_reg;
            c_rem_reg <= rem;
            c_usum_reg <= b_usum_reg;
            c_base_reg <= b_base_reg;
            c_q_reg <= qpad[SW-1:0];
        end
        if (c_valid_reg && en_d)
        begin
            d_fail_reg <= fail;
            d_m_reg <= m_val;
            d_sec_reg <= c_base_reg + c_q_reg;
        end
        if (d_valid_reg && en_out)
        begin
            if (d_fail_reg)
            begin
                status_reg <= ptta_pkg::STATUS_NOT_FILLED;
                avg_sec_reg <= '0;
                avg_us_reg <= '0;
            end
            else
            begin
                status_reg <= ptta_pkg::STATUS_OK;
                avg_sec_reg <= d_sec_reg + SW'(carry_s);
                avg_us_reg <= UW0'(d_m_reg - carry_sub);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign avg_seconds = avg_sec_reg;
    assign avg_microseconds = avg_us_reg;

endmodule

FILE: dv/tb_pulse_train_timestamp_averager_unit.sv
// testbench for the pulse train timestamp averager: random pulse trains and ticks, self-checking
`timescale 1ns / 1ps

module tb_pulse_train_timestamp_averager_unit;

    localparam int SEC_W = ptta_pkg::SEC_W;
    localparam int USEC_W = ptta_pkg::USEC_W;
    localparam int CFG_W = ptta_pkg::CFG_W;
    localparam int CFG_IDX_W = ptta_pkg::CFG_IDX_W;
    localparam int USEC_PER_SEC = ptta_pkg::USEC_PER_SEC;
    localparam int PULSE_COUNT = 4;
    localparam int LAST = PULSE_COUNT - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [SEC_W-1:0]  secs;
        logic [USEC_W-1:0] usecs;
    } pulse_word_t;

    typedef struct packed {
        logic              status;
        logic [SEC_W-1:0]  secs;
        logic [USEC_W-1:0] usecs;
    } avg_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic event_kind = ptta_pkg::EVENT_PULSE;
    logic [SEC_W-1:0] time_seconds = '0;
    logic [USEC_W-1:0] time_microseconds = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic status;
    logic [SEC_W-1:0] avg_seconds;
    logic [USEC_W-1:0] avg_microseconds;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = ptta_pkg::REG_PULSE_SPACING;
    logic [CFG_W-1:0] cfg_data = '0;

    // timestamp history, newest at index 0
    logic [SEC_W-1:0] hist_sec [PULSE_COUNT];
    logic [USEC_W-1:0] hist_usec [PULSE_COUNT];
    bit train_armed;
    logic [CFG_W-1:0] spacing_cfg = ptta_pkg::SPACING_RESET;
    logic [CFG_W-1:0] settle_cfg = ptta_pkg::SETTLE_RESET;
    logic [CFG_W-1:0] margin_cfg = ptta_pkg::MARGIN_RESET;

    pulse_word_t pulse_words [$];
    avg_word_t pending_avgs [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int words_sent = 0;
    int words_queued = 0;
    int avg_ok_cnt = 0;
    int not_filled_cnt = 0;
    int settings_used = 1;
    int err_cnt = 0;
    int cyc = 0;

    pulse_train_timestamp_averager_unit #(
        .PULSE_COUNT(PULSE_COUNT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .event_kind(event_kind),
        .time_seconds(time_seconds),
        .time_microseconds(time_microseconds),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .avg_seconds(avg_seconds),
        .avg_microseconds(avg_microseconds),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint usec_delta(logic [SEC_W-1:0] as, logic [USEC_W-1:0] aus,
                                          logic [SEC_W-1:0] bs, logic [USEC_W-1:0] bus);
        return (longint'(as) - longint'(bs)) * USEC_PER_SEC + longint'(aus) - longint'(bus);
    endfunction

    function automatic longint floor_div(longint n, longint d);
        if (n >= 0)
            return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic void track_word(logic kind, logic [SEC_W-1:0] ts,
                                       logic [USEC_W-1:0] tus);
        longint ds;
        longint d;
        longint span;
        longint limit;
        longint sum;
        longint total;
        longint secs;
        bit elapsed;
        avg_word_t r;
        if (kind == ptta_pkg::EVENT_PULSE)
        begin
            for (int i = LAST; i > 0; i--)
            begin
                hist_sec[i] = hist_sec[i-1];
                hist_usec[i] = hist_usec[i-1];
            end
            hist_sec[0] = ts;
            hist_usec[0] = tus;
            train_armed = 1'b1;
            return;
        end
        if (!train_armed)
            return;
        ds = longint'(ts) - longint'(hist_sec[0]);
        if (ds < 0 || ds > 1)
            elapsed = 1'b1;
        else
        begin
            d = usec_delta(ts, tus, hist_sec[0], hist_usec[0]);
            elapsed = (d < 0) || (d > longint'(settle_cfg));
        end
        if (!elapsed)
            return;
        train_armed = 1'b0;
        span = usec_delta(hist_sec[0], hist_usec[0], hist_sec[LAST], hist_usec[LAST]);
        limit = longint'(spacing_cfg) * LAST + longint'(margin_cfg);
        if (span < 0 || span > limit)
        begin
            r.status = ptta_pkg::STATUS_NOT_FILLED;
            r.secs = '0;
            r.usecs = '0;
        end
        else
        begin
            sum = 0;
            for (int i = 0; i < LAST; i++)
                sum += usec_delta(hist_sec[i], hist_usec[i], hist_sec[LAST], hist_usec[LAST])
                       + longint'(LAST - i) * longint'(spacing_cfg);
            total = longint'(hist_usec[LAST]) + floor_div(sum, PULSE_COUNT);
            secs = floor_div(total, USEC_PER_SEC);
            r.status = ptta_pkg::STATUS_OK;
            r.usecs = USEC_W'(total - secs * USEC_PER_SEC);
            r.secs = SEC_W'(secs + longint'(hist_sec[LAST]));
        end
        pending_avgs.push_back(r);
    endfunction

    initial
    begin
        for (int i = 0; i < PULSE_COUNT; i++)
        begin
            hist_sec[i] = '0;
            hist_usec[i] = '0;
        end
        train_armed = 1'b0;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        pulse_word_t w;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                track_word(event_kind, time_seconds, time_microseconds);
                words_sent++;
            end
            if (pulse_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                w = pulse_words.pop_front();
                in_valid <= 1'b1;
                event_kind <= w.kind;
                time_seconds <= w.secs;
                time_microseconds <= w.usecs;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        avg_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_avgs.size() == 0)
            begin
                $display("%0t: unexpected word: status %0d seconds %0d usec %0d", $time,
                         status, avg_seconds, avg_microseconds);
                err_cnt++;
            end
            else
            begin
                e = pending_avgs.pop_front();
                if (e.status !== status || e.secs !== avg_seconds
                    || e.usecs !== avg_microseconds)
                begin
                    $display("%0t: mismatch: expected status %0d seconds %0d usec %0d,",
                             $time, e.status, e.secs, e.usecs);
                    $display("    got status %0d seconds %0d usec %0d",
                             status, avg_seconds, avg_microseconds);
                    err_cnt++;
                end
                if (e.status == ptta_pkg::STATUS_OK)
                    avg_ok_cnt++;
                else
                    not_filled_cnt++;
            end
        end
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d averages outstanding", $time, pending_avgs.size());
            $display("tb_pulse_train_timestamp_averager_unit: FAIL");
            $finish;
        end
    end

    task automatic push_raw(logic kind, logic [SEC_W-1:0] secs, logic [USEC_W-1:0] usecs);
        pulse_word_t w;
        w.kind = kind;
        w.secs = secs;
        w.usecs = usecs;
        pulse_words.push_back(w);
        words_queued++;
    endtask

    task automatic push_at(logic kind, longint t_us);
        if (t_us < 0)
            t_us = 0;
        push_raw(kind, SEC_W'(t_us / USEC_PER_SEC), USEC_W'(t_us % USEC_PER_SEC));
    endtask

    // checked between edges so that words just handed over are seen
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pulse_words.size() != 0 || in_valid || pending_avgs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            ptta_pkg::REG_PULSE_SPACING: spacing_cfg = val;
            ptta_pkg::REG_SETTLE_WAIT: settle_cfg = val;
            ptta_pkg::REG_SPAN_MARGIN: margin_cfg = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic gen_train();
        logic [SEC_W-1:0] base_s;
        longint t;
        longint tn;
        longint jit;
        int n;
        int n_early;
        int mode;
        base_s = $urandom();
        if ($urandom_range(0, 15) == 0)
            base_s = 32'hFFFF_FFFF - $urandom_range(0, 3);
        t = longint'(base_s) * USEC_PER_SEC + $urandom_range(0, USEC_PER_SEC - 1);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : PULSE_COUNT;
        jit = ($urandom_range(0, 4) == 0) ? longint'(spacing_cfg) + longint'(margin_cfg)
                                          : longint'(margin_cfg) / 6;
        tn = t;
        for (int k = 0; k < n; k++)
        begin
            push_at(ptta_pkg::EVENT_PULSE, t);
            tn = (t < 0) ? 0 : t;
            t = tn + longint'(spacing_cfg)
                + longint'($urandom_range(0, 32'(2 * jit))) - jit;
        end
        n_early = $urandom_range(0, 2);
        for (int k = 0; k < n_early; k++)
            push_at(ptta_pkg::EVENT_TICK, tn + $urandom_range(0, settle_cfg));
        mode = $urandom_range(0, 9);
        if (mode < 7)
            push_at(ptta_pkg::EVENT_TICK, tn + settle_cfg + $urandom_range(1, 200000));
        else if (mode == 7)
            push_at(ptta_pkg::EVENT_TICK, tn + longint'($urandom_range(2, 5)) * USEC_PER_SEC
                    + $urandom_range(0, USEC_PER_SEC - 1));
        else if (mode == 8)
            push_at(ptta_pkg::EVENT_TICK, tn - $urandom_range(1, 500000));
        if ($urandom_range(0, 5) == 0)
            push_raw(logic'($urandom_range(0, 1)), $urandom(),
                     USEC_W'($urandom_range(0, 20'hFFFFF)));
    endtask

    initial
    begin
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // tick with nothing armed
        push_raw(ptta_pkg::EVENT_TICK, 32'd0, 20'd0);
        // lone pulse, history mostly zero
        push_raw(ptta_pkg::EVENT_PULSE, 32'd5, 20'd0);
        push_raw(ptta_pkg::EVENT_TICK, 32'd5, 20'd400000);
        // clean train, one tick inside the settle wait
        push_raw(ptta_pkg::EVENT_PULSE, 32'd10, 20'd0);
        push_raw(ptta_pkg::EVENT_PULSE, 32'd10, 20'd200000);
        push_raw(ptta_pkg::EVENT_PULSE, 32'd10, 20'd400000);
        push_raw(ptta_pkg::EVENT_PULSE, 32'd10, 20'd600000);
        push_raw(ptta_pkg::EVENT_TICK, 32'd10, 20'd800000);
        push_raw(ptta_pkg::EVENT_TICK, 32'd10, 20'd900001);
        // gap of more than one second
        push_raw(ptta_pkg::EVENT_PULSE, 32'd21, 20'd0);
        push_raw(ptta_pkg::EVENT_TICK, 32'd23, 20'd0);
        // tick before newest pulse, microseconds over range
        push_raw(ptta_pkg::EVENT_PULSE, 32'd31, 20'hFFFFF);
        push_raw(ptta_pkg::EVENT_TICK, 32'd31, 20'd0);
        // negative mean borrows from seconds
        push_raw(ptta_pkg::EVENT_PULSE, 32'd50, 20'd0);
        push_raw(ptta_pkg::EVENT_PULSE, 32'd49, 20'd0);
        push_raw(ptta_pkg::EVENT_PULSE, 32'd49, 20'd0);
        push_raw(ptta_pkg::EVENT_PULSE, 32'd50, 20'd100);
        push_raw(ptta_pkg::EVENT_TICK, 32'd51, 20'd0);
        // seconds wrap, negative span
        push_raw(ptta_pkg::EVENT_PULSE, 32'hFFFF_FFFF, 20'd500000);
        push_raw(ptta_pkg::EVENT_PULSE, 32'hFFFF_FFFF, 20'd700000);
        push_raw(ptta_pkg::EVENT_PULSE, 32'hFFFF_FFFF, 20'd900000);
        push_raw(ptta_pkg::EVENT_PULSE, 32'd0, 20'd100000);
        push_raw(ptta_pkg::EVENT_TICK, 32'd0, 20'd500000);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                1:
                begin
                    write_reg(ptta_pkg::REG_PULSE_SPACING, 20'd1);
                    write_reg(ptta_pkg::REG_SETTLE_WAIT, 20'd0);
                    write_reg(ptta_pkg::REG_SPAN_MARGIN, 20'd0);
                end
                2:
                begin
                    write_reg(ptta_pkg::REG_PULSE_SPACING, 20'd999999);
                    write_reg(ptta_pkg::REG_SETTLE_WAIT, 20'd999999);
                    write_reg(ptta_pkg::REG_SPAN_MARGIN, 20'd999999);
                end
                4:
                begin
                    write_reg(ptta_pkg::REG_PULSE_SPACING, 20'd333333);
                    write_reg(ptta_pkg::REG_SETTLE_WAIT, 20'd150000);
                    write_reg(ptta_pkg::REG_SPAN_MARGIN, 20'd0);
                    write_reg(REG_UNUSED, CFG_W'($urandom()));
                end
                3, 5:
                begin
                    write_reg(ptta_pkg::REG_PULSE_SPACING, CFG_W'($urandom_range(1, 999999)));
                    write_reg(ptta_pkg::REG_SETTLE_WAIT, CFG_W'($urandom_range(0, 999999)));
                    write_reg(ptta_pkg::REG_SPAN_MARGIN, CFG_W'($urandom_range(0, 999999)));
                end
                default: ;
            endcase
            if (ph != 0)
                settings_used++;
            send_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 65 : 0;
            stall_pct = (ph < 2) ? 65 : (ph < 4) ? 9 : 0;
            target = words_queued + ITEMS_PER_PHASE;
            while (words_queued < target)
            begin
                gen_train();
                // sender holds off until the block has drained
                if (ph == 2 && words_queued >= target - ITEMS_PER_PHASE / 2
                    && pulse_words.size() != 0)
                begin
                    wait_idle();
                end
            end
        end
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d words over %0d register settings", words_sent, settings_used);
        $display("checked %0d averages and %0d not-filled results", avg_ok_cnt, not_filled_cnt);
        if (err_cnt == 0)
            $display("tb_pulse_train_timestamp_averager_unit: PASS");
        else
            $display("tb_pulse_train_timestamp_averager_unit: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/ptta_pkg.sv
src/pulse_train_timestamp_averager_unit.sv
dv/tb_pulse_train_timestamp_averager_unit.sv
